@@ rtl/core/tcw_pkg.sv @@
// shared types, constants and codes for the text console writer
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // internal widths derived from the geometry
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // fixed field widths of the stream payloads
    localparam int OP_W           = 2;
    localparam int CHAR_W         = 8;
    localparam int CELL_INDEX_W   = 11;
    localparam int CURSOR_COL_W   = 7;
    localparam int CURSOR_ROW_W   = 5;
    localparam int CURSOR_POS_W   = 11;
    localparam int CELL_W         = 16;
    localparam int ATTR_W         = 8;
    localparam int IN_TDATA_W     = 24;
    localparam int OUT_TDATA_W    = 40;

    // width that holds an index or address plus one carry bit
    localparam int SUM_W = ((ADDR_W > CELL_INDEX_W) ? ADDR_W : CELL_INDEX_W) + 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // tab stops
    localparam int TAB_STEP = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

    // classified command kinds
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PRINT,
        CMD_BS,
        CMD_TAB,
        CMD_CR,
        CMD_LF,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    // one classified command
    typedef struct packed {
        cmd_kind_t           kind;
        logic [CHAR_W-1:0]   ch;
        logic [ADDR_W-1:0]   index;
        logic                in_range;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [CELL_W-1:0]       cell_data;
        logic [CURSOR_POS_W-1:0] cursor_pos;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_col;
    } result_t;

    // back end states
    typedef enum logic [1:0] {
        BS_INIT,
        BS_IDLE,
        BS_FILL,
        BS_READ
    } back_state_t;

endpackage

@@ rtl/core/text_console_writer.sv @@
// Text console writer: an 80x25 screen of 16-bit cells (attribute high byte,
// character low byte) with a cursor. Every input beat gives exactly one result
// beat with the cursor column, row and linear position, plus the cell contents
// for a read. Cursor moves and character writes are done as the command is
// taken; a read passes a read state for the registered store read. Clear writes
// every cell, one per cycle; a scroll re-blanks one row, because the screen is
// kept as a rotating ring of rows in the store. After reset the store is swept
// to zero, during which s_tready stays low; the attribute register can be
// written at any time the block is idle. A two-entry command queue and an
// output register let input and output stall separately.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ATTR_W-1:0]      cfg_data,   // attribute
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // op, char_code, cell_index
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata     // cursor_col, cursor_row, cursor_pos, cell_data
);

    logic [ATTR_W-1:0] attribute_reg, attribute_next;
    logic              push_valid, push_ready;
    cmd_t              push_cmd;
    logic              pop_valid, pop_ready;
    cmd_t              pop_cmd;
    logic              init_busy;
    result_t           result;

    // attribute register
    assign cfg_ready      = 1'b1;
    assign attribute_next = (cfg_valid && cfg_ready) ? cfg_data : attribute_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_reg <= '0;
        end
        else
        begin
            attribute_reg <= attribute_next;
        end
    end

    // front end
    tcw_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .init_busy  (init_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    tcw_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // back end
    tcw_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .attribute (attribute_reg),
        .cmd_valid (pop_valid),
        .cmd_pop   (pop_ready),
        .cmd       (pop_cmd),
        .init_busy (init_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // pack the result beat
    assign m_tdata = {1'b0, result.cell_data, result.cursor_pos,
                      result.cursor_row, result.cursor_col};

endmodule

@@ rtl/core/tcw_front.sv @@
// input side: takes stream beats and classifies them into commands
module tcw_front
    import tcw_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,    // op, char_code, cell_index
    input  logic                  init_busy,
    output logic                  push_valid,
    input  logic                  push_ready,
    output cmd_t                  push_cmd
);

    logic [OP_W-1:0]         op;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_INDEX_W-1:0] cell_index;

    // unpack the beat
    assign op         = s_tdata[OP_W-1:0];
    assign char_code  = s_tdata[OP_W+CHAR_W-1:OP_W];
    assign cell_index = s_tdata[OP_W+CHAR_W+CELL_INDEX_W-1:OP_W+CHAR_W];

    // no beats taken while the store is still being cleared after reset
    assign s_tready   = push_ready & ~init_busy;
    assign push_valid = s_tvalid & ~init_busy;

    // decode operation and character class
    always_comb
    begin
        push_cmd.ch       = char_code;
        push_cmd.index    = ADDR_W'(cell_index);
        push_cmd.in_range = SUM_W'(cell_index) < SUM_W'(CELLS);
        push_cmd.kind     = CMD_NOP;
        case (op)
            OP_PUT:
            begin
                case (char_code) inside
                    CH_BS:                    push_cmd.kind = CMD_BS;
                    CH_TAB:                   push_cmd.kind = CMD_TAB;
                    CH_CR:                    push_cmd.kind = CMD_CR;
                    CH_LF:                    push_cmd.kind = CMD_LF;
                    [CH_SPACE:CH_PRINT_LAST]: push_cmd.kind = CMD_PRINT;
                    default:                  push_cmd.kind = CMD_NOP;
                endcase
            end
            OP_CLEAR: push_cmd.kind = CMD_CLEAR;
            OP_READ:  push_cmd.kind = CMD_READ;
            default:  push_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

@@ rtl/core/tcw_queue.sv @@
// short command queue between the front and back ends
module tcw_queue
    import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/tcw_back.sv @@
// back end: cursor, screen store, scroll and clear sweeps, result register
module tcw_back
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ATTR_W-1:0] attribute,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  cmd_t              cmd,
    output logic              init_busy,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           result
);

    localparam int CW1 = COL_W + 1;
    localparam int AW1 = ADDR_W + 1;

    // screen store, rotated by top_reg so a scroll only blanks one row
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    back_state_t       state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] log_base_reg, log_base_next;
    logic [ADDR_W-1:0] phys_base_reg, phys_base_next;
    logic [ADDR_W-1:0] top_reg, top_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0] fill_last_reg, fill_last_next;
    logic              fill_zero_reg, fill_zero_next;
    logic              read_ok_reg, read_ok_next;
    logic              out_valid_reg, out_valid_next;

    logic [CURSOR_COL_W-1:0] res_col_reg, res_col_next;
    logic [CURSOR_ROW_W-1:0] res_row_reg, res_row_next;
    logic [CURSOR_POS_W-1:0] res_pos_reg, res_pos_next;
    logic [CELL_W-1:0]       res_cell_reg, res_cell_next;

    logic [CW1-1:0]    col_ext, col_tab, col_calc;
    logic              col_wrap, row_step, at_bottom;
    logic [COL_W-1:0]  col_new;
    logic [AW1-1:0]    phys_sum, top_sum, read_sum;
    logic [ADDR_W-1:0] phys_base_inc, top_inc, read_addr, pos_sum;
    logic [CELL_W-1:0] blank_cell;

    assign blank_cell = {attribute, CH_SPACE};
    assign init_busy  = state_reg == BS_INIT;
    assign out_valid  = out_valid_reg;

    assign result.cursor_col = res_col_reg;
    assign result.cursor_row = res_row_reg;
    assign result.cursor_pos = res_pos_reg;
    assign result.cell_data  = res_cell_reg;

    // cursor column arithmetic for the control and printable characters
    assign col_ext = {1'b0, col_reg};
    assign col_tab = (col_ext + CW1'(TAB_STEP)) & ~CW1'(TAB_STEP-1);

    always_comb
    begin
        case (cmd.kind)
            CMD_PRINT: col_calc = col_ext + CW1'(1);
            CMD_BS:    col_calc = (col_reg != '0) ? col_ext - CW1'(1) : col_ext;
            CMD_TAB:   col_calc = col_tab;
            CMD_CR:    col_calc = '0;
            CMD_LF:    col_calc = '0;
            default:   col_calc = col_ext;
        endcase
    end

    assign col_wrap  = col_calc >= CW1'(COLUMNS);
    assign row_step  = col_wrap | (cmd.kind == CMD_LF);
    assign col_new   = col_wrap ? '0 : col_calc[COL_W-1:0];
    assign at_bottom = row_reg == ROW_W'(ROWS-1);

    // row start addresses step by one row, wrapping round the store
    assign phys_sum      = {1'b0, phys_base_reg} + AW1'(COLUMNS);
    assign phys_base_inc = (phys_sum == AW1'(CELLS)) ? '0 : phys_sum[ADDR_W-1:0];
    assign top_sum       = {1'b0, top_reg} + AW1'(COLUMNS);
    assign top_inc       = (top_sum == AW1'(CELLS)) ? '0 : top_sum[ADDR_W-1:0];

    // physical address of a screen index
    always_comb
    begin
        read_sum = AW1'(cmd.index) + AW1'(top_reg);
        if (read_sum >= AW1'(CELLS))
        begin
            read_sum = read_sum - AW1'(CELLS);
        end
        read_addr = read_sum[ADDR_W-1:0];
    end

    // next state and store control
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        log_base_next  = log_base_reg;
        phys_base_next = phys_base_reg;
        top_next       = top_reg;
        fill_addr_next = fill_addr_reg;
        fill_last_next = fill_last_reg;
        fill_zero_next = fill_zero_reg;
        read_ok_next   = read_ok_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        res_pos_next   = res_pos_reg;
        res_cell_next  = res_cell_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_addr_reg;
        mem_wdata      = fill_zero_reg ? '0 : blank_cell;
        mem_raddr      = read_addr;
        cmd_pop        = 1'b0;
        pos_sum        = '0;

        case (state_reg)
            BS_INIT, BS_FILL:
            begin
                // one cell per cycle until the last address of the sweep
                mem_we = 1'b1;
                if (fill_addr_reg == fill_last_reg)
                begin
                    state_next     = BS_IDLE;
                    fill_zero_next = 1'b0;
                    if (state_reg == BS_FILL)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            BS_READ:
            begin
                res_cell_next  = read_ok_reg ? rd_data_reg : '0;
                out_valid_next = 1'b1;
                state_next     = BS_IDLE;
            end
            BS_IDLE:
            begin
                if (cmd_valid && (!out_valid_reg || out_ready))
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    res_cell_next  = '0;
                    case (cmd.kind)
                        CMD_CLEAR:
                        begin
                            col_next       = '0;
                            row_next       = '0;
                            log_base_next  = '0;
                            phys_base_next = '0;
                            top_next       = '0;
                            fill_addr_next = '0;
                            fill_last_next = ADDR_W'(CELLS-1);
                            state_next     = BS_FILL;
                            out_valid_next = 1'b0;
                        end
                        CMD_READ:
                        begin
                            read_ok_next   = cmd.in_range;
                            state_next     = BS_READ;
                            out_valid_next = 1'b0;
                        end
                        default:
                        begin
                            // printable characters land at the cursor
                            if (cmd.kind == CMD_PRINT)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = phys_base_reg + ADDR_W'(col_reg);
                                mem_wdata = {attribute, cmd.ch};
                            end
                            col_next = col_new;
                            if (row_step)
                            begin
                                phys_base_next = phys_base_inc;
                                if (at_bottom)
                                begin
                                    // scroll: old top row becomes the blank last row
                                    fill_addr_next = top_reg;
                                    fill_last_next = top_reg + ADDR_W'(COLUMNS-1);
                                    top_next       = top_inc;
                                    state_next     = BS_FILL;
                                    out_valid_next = 1'b0;
                                end
                                else
                                begin
                                    row_next      = row_reg + 1'b1;
                                    log_base_next = log_base_reg + ADDR_W'(COLUMNS);
                                end
                            end
                        end
                    endcase
                    // cursor report for this command
                    pos_sum      = log_base_next + ADDR_W'(col_next);
                    res_col_next = CURSOR_COL_W'(col_next);
                    res_row_next = CURSOR_ROW_W'(row_next);
                    res_pos_next = CURSOR_POS_W'(pos_sum);
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            log_base_reg  <= '0;
            phys_base_reg <= '0;
            top_reg       <= '0;
            fill_addr_reg <= '0;
            fill_last_reg <= ADDR_W'(CELLS-1);
            fill_zero_reg <= 1'b1;
            read_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            log_base_reg  <= log_base_next;
            phys_base_reg <= phys_base_next;
            top_reg       <= top_next;
            fill_addr_reg <= fill_addr_next;
            fill_last_reg <= fill_last_next;
            fill_zero_reg <= fill_zero_next;
            read_ok_reg   <= read_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        res_pos_reg  <= res_pos_next;
        res_cell_reg <= res_cell_next;
    end

    // screen store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule
